FILE: rtl/fdrs_pkg.sv
package fdrs_pkg;

  localparam int unsigned DEF_QUEUE_DEPTH = 32;
  localparam int unsigned DEF_ID_BITS     = 8;
  localparam int unsigned DEF_TRACK_BITS  = 16;

  localparam logic OP_ADD = 1'b0;
  localparam logic OP_GET = 1'b1;

  typedef enum logic [1:0] {
    ST_ADDED    = 2'd0,
    ST_SELECTED = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

endpackage

FILE: rtl/fdrs_ram.sv
module fdrs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

FILE: rtl/flook_disk_request_scheduler_top.sv
// Add: the result is registered and moves to the output registers in S_RESP once the output is free.
// Get: S_SCAN reads the n entries of the active queue through the single RAM read port,
//   S_PICK takes the selected entry, S_SHIFT closes the gap at removed slot k unless it
//   is the last, and S_RESP moves the result to the output registers once they are free.
// One item at a time; the next transfer is taken once the result is queued.
// rst_ni clears both fill levels and makes the second queue active; RAM is not cleared.
module flook_disk_request_scheduler_top
  import fdrs_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = fdrs_pkg::DEF_QUEUE_DEPTH,
  parameter int unsigned ID_BITS     = fdrs_pkg::DEF_ID_BITS,
  parameter int unsigned TRACK_BITS  = fdrs_pkg::DEF_TRACK_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  opcode_i,
  input  logic [ID_BITS-1:0]    request_id_i,
  input  logic [TRACK_BITS-1:0] track_i,
  input  logic [TRACK_BITS-1:0] head_now_i,
  input  logic [TRACK_BITS-1:0] head_before_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [1:0]            status_o,
  output logic [ID_BITS-1:0]    chosen_id_o,
  output logic [TRACK_BITS-1:0] chosen_track_o
);

  localparam int unsigned IDX_W  = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned ADDR_W = IDX_W + 1;
  localparam int unsigned ENT_W  = ID_BITS + TRACK_BITS;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN  = 5'b00010,
    S_PICK  = 5'b00100,
    S_SHIFT = 5'b01000,
    S_RESP  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  logic [CNT_W-1:0] cnt_q [2];
  logic [CNT_W-1:0] cnt_d [2];
  logic             act_q, act_d;

  logic [TRACK_BITS-1:0] pos_q, pos_d;
  logic                  up_q, up_d;
  logic [CNT_W-1:0]      n_q, n_d;
  logic [CNT_W-1:0]      issue_q, issue_d;
  logic                  dv_q, dv_d;
  logic [IDX_W-1:0]      cidx_q, cidx_d;

  logic                  fa_q, fa_d, fb_q, fb_d;
  logic [TRACK_BITS-1:0] da_q, da_d, db_q, db_d;
  logic [IDX_W-1:0]      ia_q, ia_d, ib_q, ib_d;
  logic [ENT_W-1:0]      ea_q, ea_d, eb_q, eb_d;

  status_e               res_st_q, res_st_d;
  logic [ID_BITS-1:0]    res_id_q, res_id_d;
  logic [TRACK_BITS-1:0] res_trk_q, res_trk_d;

  logic                  out_valid_q, out_valid_d;
  status_e               out_st_q, out_st_d;
  logic [ID_BITS-1:0]    out_id_q, out_id_d;
  logic [TRACK_BITS-1:0] out_trk_q, out_trk_d;

  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [ENT_W-1:0]  ram_wdata, ram_rdata;

  logic                  in_xfer;
  logic [TRACK_BITS-1:0] rd_trk, d_up, d_dn, dist_a, dist_b;
  logic                  ge, le, qual_a, qual_b, out_free, last_rd;
  logic [IDX_W-1:0]      where_idx;
  logic [ENT_W-1:0]      where_ent;

  fdrs_ram #(
    .WIDTH (ENT_W),
    .DEPTH (2 ** ADDR_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign in_stall_o     = (state_q != S_IDLE);
  assign in_xfer        = in_valid_i && !in_stall_o;
  assign out_valid_o    = out_valid_q;
  assign status_o       = out_st_q;
  assign chosen_id_o    = out_id_q;
  assign chosen_track_o = out_trk_q;
  assign out_free       = !out_valid_q || !out_stall_i;

  assign rd_trk = ram_rdata[TRACK_BITS-1:0];
  assign ge     = rd_trk >= pos_q;
  assign le     = rd_trk <= pos_q;
  assign d_up   = rd_trk - pos_q;
  assign d_dn   = pos_q - rd_trk;
  assign qual_a = up_q ? ge : le;
  assign qual_b = up_q ? le : ge;
  assign dist_a = up_q ? d_up : d_dn;
  assign dist_b = up_q ? d_dn : d_up;
  assign last_rd = dv_q && (CNT_W'(cidx_q) == n_q - CNT_W'(1));

  assign where_idx = fa_q ? ia_q : ib_q;
  assign where_ent = fa_q ? ea_q : eb_q;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    act_d       = act_q;
    pos_d       = pos_q;
    up_d        = up_q;
    n_d         = n_q;
    issue_d     = issue_q;
    cidx_d      = issue_q[IDX_W-1:0];
    fa_d        = fa_q;
    fb_d        = fb_q;
    da_d        = da_q;
    db_d        = db_q;
    ia_d        = ia_q;
    ib_d        = ib_q;
    ea_d        = ea_q;
    eb_d        = eb_q;
    res_st_d    = res_st_q;
    res_id_d    = res_id_q;
    res_trk_d   = res_trk_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_st_d    = out_st_q;
    out_id_d    = out_id_q;
    out_trk_d   = out_trk_q;
    ram_we      = 1'b0;
    ram_waddr   = {!act_q, issue_q[IDX_W-1:0]};
    ram_wdata   = ram_rdata;
    ram_re      = 1'b0;
    ram_raddr   = {act_q, issue_q[IDX_W-1:0]};

    if (state_q == S_SCAN || state_q == S_SHIFT) begin
      ram_re  = issue_q < n_q;
      issue_d = ram_re ? issue_q + CNT_W'(1) : issue_q;
    end
    dv_d = ram_re;

    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          res_id_d  = '0;
          res_trk_d = '0;
          state_d   = S_RESP;
          if (opcode_i == OP_ADD) begin
            if (cnt_q[!act_q] >= CNT_W'(QUEUE_DEPTH)) begin
              res_st_d = ST_FULL;
            end else begin
              res_st_d          = ST_ADDED;
              ram_we            = 1'b1;
              ram_waddr         = {!act_q, cnt_q[!act_q][IDX_W-1:0]};
              ram_wdata         = {request_id_i, track_i};
              cnt_d[!act_q]     = cnt_q[!act_q] + CNT_W'(1);
            end
          end else if (cnt_q[0] == '0 && cnt_q[1] == '0) begin
            res_st_d = ST_EMPTY;
          end else begin
            act_d   = (cnt_q[act_q] == '0) ? !act_q : act_q;
            n_d     = cnt_q[act_d];
            pos_d   = head_now_i;
            up_d    = head_now_i >= head_before_i;
            issue_d = '0;
            fa_d    = 1'b0;
            fb_d    = 1'b0;
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (dv_q) begin
          if (qual_a && (!fa_q || dist_a < da_q)) begin
            fa_d = 1'b1;
            da_d = dist_a;
            ia_d = cidx_q;
            ea_d = ram_rdata;
          end
          if (qual_b && (!fb_q || dist_b < db_q)) begin
            fb_d = 1'b1;
            db_d = dist_b;
            ib_d = cidx_q;
            eb_d = ram_rdata;
          end
        end
        if (last_rd) begin
          state_d = S_PICK;
        end
      end
      S_PICK: begin
        res_st_d     = ST_SELECTED;
        res_id_d     = where_ent[ENT_W-1:TRACK_BITS];
        res_trk_d    = where_ent[TRACK_BITS-1:0];
        cnt_d[act_q] = cnt_q[act_q] - CNT_W'(1);
        issue_d      = CNT_W'(where_idx) + CNT_W'(1);
        state_d      = (issue_d < n_q) ? S_SHIFT : S_RESP;
      end
      S_SHIFT: begin
        if (dv_q) begin
          ram_we    = 1'b1;
          ram_waddr = {act_q, cidx_q - IDX_W'(1)};
          ram_wdata = ram_rdata;
        end
        if (last_rd) begin
          state_d = S_RESP;
        end
      end
      S_RESP: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_st_d    = res_st_q;
          out_id_d    = res_id_q;
          out_trk_d   = res_trk_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q[0]    <= '0;
      cnt_q[1]    <= '0;
      act_q       <= 1'b1;
      dv_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      act_q       <= act_d;
      dv_q        <= dv_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q     <= pos_d;
    up_q      <= up_d;
    n_q       <= n_d;
    issue_q   <= issue_d;
    cidx_q    <= cidx_d;
    fa_q      <= fa_d;
    fb_q      <= fb_d;
    da_q      <= da_d;
    db_q      <= db_d;
    ia_q      <= ia_d;
    ib_q      <= ib_d;
    ea_q      <= ea_d;
    eb_q      <= eb_d;
    res_st_q  <= res_st_d;
    res_id_q  <= res_id_d;
    res_trk_q <= res_trk_d;
    out_st_q  <= out_st_d;
    out_id_q  <= out_id_d;
    out_trk_q <= out_trk_d;
  end

endmodule

FILE: rtl/fdrs_checker.sv
module fdrs_checker #(
  parameter int unsigned ID_BITS    = fdrs_pkg::DEF_ID_BITS,
  parameter int unsigned TRACK_BITS = fdrs_pkg::DEF_TRACK_BITS
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_stall_o,
  input logic                  opcode_i,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input logic [1:0]            status_o,
  input logic [ID_BITS-1:0]    chosen_id_o,
  input logic [TRACK_BITS-1:0] chosen_track_o
);
  import fdrs_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o)
      && $stable(chosen_id_o) && $stable(chosen_track_o))
    else $error("stalled result changed");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("transfer taken while an item is in work");

  a_zero_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_SELECTED |-> chosen_id_o == '0 && chosen_track_o == '0)
    else $error("chosen fields nonzero without a selection");

  a_add_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && opcode_i == OP_ADD && !out_valid_o |=> ##1
      out_valid_o && (status_o == ST_ADDED || status_o == ST_FULL))
    else $error("add gave a wrong status");

endmodule

bind flook_disk_request_scheduler_top fdrs_checker #(
  .ID_BITS    (ID_BITS),
  .TRACK_BITS (TRACK_BITS)
) u_fdrs_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .opcode_i       (opcode_i),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .status_o       (status_o),
  .chosen_id_o    (chosen_id_o),
  .chosen_track_o (chosen_track_o)
);
